// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, muted while reset is asserted.
`define CPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sequencer assertion failed");

// Check on every rising edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sequencer reset assertion failed");

`endif

// ===== src/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants for the contactor precharge sequencer.
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int PHASE_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF = 20;

	// Input item: sync, command, four bus flags, phase, startup, clear faults
	localparam int IN_FIXED_BITS = 9;
	localparam int PHASE_LSB     = 7;

	// Result item packs into 12 bits, sent as two bytes
	localparam int OUT_BITS = 16;

	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PRECHARGE_TICKS   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHARGE_TICKS      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSE_WINDOW_LOW  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSE_WINDOW_HIGH = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NEAR_WRAP_PHASE   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSED_SURE_PHASE = 3'd5;

	localparam logic [31:0] PRECHARGE_TICKS_RST   = 32'd1000;
	localparam logic [31:0] CHARGE_TICKS_RST      = 32'd1000;
	localparam logic [31:0] CLOSE_WINDOW_LOW_RST  = 32'd60000;
	localparam logic [31:0] CLOSE_WINDOW_HIGH_RST = 32'd62000;
	localparam logic [31:0] NEAR_WRAP_PHASE_RST   = 32'd65000;
	localparam logic [31:0] CLOSED_SURE_PHASE_RST = 32'd5000;

	localparam logic [1:0] CMD_KEEP  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_OFF       = 3'd0,
		ST_PRECHARGE = 3'd1,
		ST_WAIT      = 3'd2,
		ST_DWELL     = 3'd3,
		ST_CHARGE    = 3'd4,
		ST_CLOSED    = 3'd5
	} stage_t;

endpackage

// ===== src/contactor_precharge_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// contactor_precharge_sequencer_unit
// AC contactor precharge sequencer, one control tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one control tick per request: grid sync, close command, bus
//   undervoltage flags, grid phase, startup pulse and fault clear.
//   m_* returns one result per tick: stage, active-low relay/opto/LED drives,
//   latched faults, close request and the fault-reset pulse.
//   cfg_* writes the timeout counts and phase thresholds; write only while
//   no tick is in flight. Indexes above five are ignored.
// Timing:
//   A request is taken into the input register, then its result is written
//   to the result register by a single pass of compare, count and stage
//   logic. One request is taken every cycle while the result register is
//   free or its result is being taken.
// Reset:
//   arst_n clears the stage to off, counters, latches and both valid flags,
//   and loads the threshold registers with their defaults.
// Stall:
//   While m_tready is low the result holds; one more request is taken into
//   the input register, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module contactor_precharge_sequencer_unit #(
	parameter int PHASE_BITS = cps_pkg::PHASE_BITS_DEF,
	parameter int TIMER_BITS = cps_pkg::TIMER_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// s_tdata, from bit 0: grid_sync, request_command[1:0], uv2_plus, uv2_minus,
	// uv_plus, uv_minus, phase, new_startup, clear_charge_faults, zero fill
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((cps_pkg::IN_FIXED_BITS + PHASE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// m_tdata, from bit 0: stage[2:0], ac_precharge_n, ac_relay_n,
	// dc_precharge_n, dc_relay_n, red_led_n, precharge_fault, charge_fault,
	// close_request, fault_reset_request, zero fill
	output logic m_tvalid,
	input  logic m_tready,
	output logic [cps_pkg::OUT_BITS-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [((TIMER_BITS > PHASE_BITS) ? TIMER_BITS : PHASE_BITS)-1:0] cfg_data
);

	localparam int IN_BITS  = ((cps_pkg::IN_FIXED_BITS + PHASE_BITS + 7) / 8) * 8;
	localparam int START_POS = cps_pkg::PHASE_LSB + PHASE_BITS;
	localparam int CLR_POS   = START_POS + 1;

	// configuration
	logic [TIMER_BITS-1:0] precharge_ticks_q, charge_ticks_q;
	logic [PHASE_BITS-1:0] close_window_low_q, close_window_high_q;
	logic [PHASE_BITS-1:0] near_wrap_phase_q, closed_sure_phase_q;

	// sequencer state
	cps_pkg::stage_t       stage_q;
	logic [TIMER_BITS-1:0] precharge_count_q, charge_count_q;
	logic                  close_request_q, startup_pending_q;
	logic                  precharge_fault_q, charge_fault_q;

	// input register
	logic               valid_s1;
	logic [IN_BITS-1:0] data_s1;

	// result register
	logic [cps_pkg::OUT_BITS-1:0] data_s2;
	logic                         valid_s2;

	logic advance;

	// next state
	cps_pkg::stage_t       stage_d;
	logic [TIMER_BITS-1:0] precharge_count_d, charge_count_d;
	logic                  close_request_d, startup_pending_d;
	logic                  precharge_fault_d, charge_fault_d;
	logic                  reset_pulse;

	// unpacked request
	logic                  in_sync, in_uv2p, in_uv2m, in_uvp, in_uvm, in_start, in_clr;
	logic [1:0]            in_cmd;
	logic [PHASE_BITS-1:0] in_phase;

	logic ac_precharge_n, ac_relay_n;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = data_s2;

	assign in_sync  = data_s1[0];
	assign in_cmd   = data_s1[2:1];
	assign in_uv2p  = data_s1[3];
	assign in_uv2m  = data_s1[4];
	assign in_uvp   = data_s1[5];
	assign in_uvm   = data_s1[6];
	assign in_phase = data_s1[START_POS-1:cps_pkg::PHASE_LSB];
	assign in_start = data_s1[START_POS];
	assign in_clr   = data_s1[CLR_POS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precharge_ticks_q   <= TIMER_BITS'(cps_pkg::PRECHARGE_TICKS_RST);
			charge_ticks_q      <= TIMER_BITS'(cps_pkg::CHARGE_TICKS_RST);
			close_window_low_q  <= PHASE_BITS'(cps_pkg::CLOSE_WINDOW_LOW_RST);
			close_window_high_q <= PHASE_BITS'(cps_pkg::CLOSE_WINDOW_HIGH_RST);
			near_wrap_phase_q   <= PHASE_BITS'(cps_pkg::NEAR_WRAP_PHASE_RST);
			closed_sure_phase_q <= PHASE_BITS'(cps_pkg::CLOSED_SURE_PHASE_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				cps_pkg::CFG_PRECHARGE_TICKS:   precharge_ticks_q   <= cfg_data[TIMER_BITS-1:0];
				cps_pkg::CFG_CHARGE_TICKS:      charge_ticks_q      <= cfg_data[TIMER_BITS-1:0];
				cps_pkg::CFG_CLOSE_WINDOW_LOW:  close_window_low_q  <= cfg_data[PHASE_BITS-1:0];
				cps_pkg::CFG_CLOSE_WINDOW_HIGH: close_window_high_q <= cfg_data[PHASE_BITS-1:0];
				cps_pkg::CFG_NEAR_WRAP_PHASE:   near_wrap_phase_q   <= cfg_data[PHASE_BITS-1:0];
				cps_pkg::CFG_CLOSED_SURE_PHASE: closed_sure_phase_q <= cfg_data[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	always_comb begin
		precharge_fault_d = in_clr ? 1'b0 : precharge_fault_q;
		charge_fault_d    = in_clr ? 1'b0 : charge_fault_q;
		close_request_d   = close_request_q;
		if (in_cmd == cps_pkg::CMD_SET) begin
			close_request_d = 1'b1;
		end else if (in_cmd == cps_pkg::CMD_CLEAR) begin
			close_request_d = 1'b0;
		end
		startup_pending_d = startup_pending_q || in_start;
		precharge_count_d = precharge_count_q;
		charge_count_d    = charge_count_q;
		reset_pulse       = 1'b0;

		// lost sync or request forces off before the stage runs
		stage_d = (!in_sync || !close_request_d) ? cps_pkg::ST_OFF : stage_q;

		case (stage_d)
			cps_pkg::ST_OFF: begin
				if (in_sync && close_request_d) begin
					stage_d           = cps_pkg::ST_PRECHARGE;
					precharge_count_d = precharge_ticks_q;
				end
			end
			cps_pkg::ST_PRECHARGE: begin
				if (precharge_count_q != '0) begin
					precharge_count_d = precharge_count_q - TIMER_BITS'(1);
				end else begin
					stage_d           = cps_pkg::ST_OFF;
					close_request_d   = 1'b0;
					precharge_fault_d = 1'b1;
				end
				// closing window still wins over the timeout
				if (!in_uv2p && !in_uv2m && in_phase > close_window_low_q
						&& in_phase < close_window_high_q) begin
					precharge_count_d = '0;
					stage_d           = cps_pkg::ST_WAIT;
				end
			end
			cps_pkg::ST_WAIT: begin
				if (in_phase > near_wrap_phase_q) begin
					stage_d = cps_pkg::ST_DWELL;
				end
			end
			cps_pkg::ST_DWELL: begin
				if (in_phase < near_wrap_phase_q && in_phase > closed_sure_phase_q) begin
					stage_d        = cps_pkg::ST_CHARGE;
					charge_count_d = charge_ticks_q;
				end
			end
			cps_pkg::ST_CHARGE: begin
				if (charge_count_q != '0) begin
					charge_count_d = charge_count_q - TIMER_BITS'(1);
				end else begin
					charge_fault_d  = 1'b1;
					stage_d         = cps_pkg::ST_OFF;
					close_request_d = 1'b0;
				end
				if (!in_uvm && !in_uvp) begin
					charge_count_d = '0;
					stage_d        = cps_pkg::ST_CLOSED;
					if (startup_pending_d) begin
						startup_pending_d = 1'b0;
						reset_pulse       = 1'b1;
					end
				end
			end
			cps_pkg::ST_CLOSED: ;
			default: begin
				stage_d         = cps_pkg::ST_OFF;
				close_request_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		ac_precharge_n = !(stage_d == cps_pkg::ST_PRECHARGE || stage_d == cps_pkg::ST_WAIT
			|| stage_d == cps_pkg::ST_DWELL);
		ac_relay_n = !(stage_d == cps_pkg::ST_WAIT || stage_d == cps_pkg::ST_DWELL
			|| stage_d == cps_pkg::ST_CHARGE || stage_d == cps_pkg::ST_CLOSED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q           <= cps_pkg::ST_OFF;
			precharge_count_q <= '0;
			charge_count_q    <= '0;
			close_request_q   <= 1'b0;
			startup_pending_q <= 1'b0;
			precharge_fault_q <= 1'b0;
			charge_fault_q    <= 1'b0;
			valid_s2          <= 1'b0;
		end else begin
			if (advance) begin
				stage_q           <= stage_d;
				precharge_count_q <= precharge_count_d;
				charge_count_q    <= charge_count_d;
				close_request_q   <= close_request_d;
				startup_pending_q <= startup_pending_d;
				precharge_fault_q <= precharge_fault_d;
				charge_fault_q    <= charge_fault_d;
				valid_s2          <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {4'b0000, reset_pulse, close_request_d, charge_fault_d,
				precharge_fault_d, ac_relay_n, 1'b1, 1'b1, ac_relay_n,
				ac_precharge_n, stage_d};
		end
	end

endmodule

// ===== src/cps_checker.sv =====
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks for the contactor precharge sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cps_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [cps_pkg::OUT_BITS-1:0] m_tdata
);

	// no result may be offered while reset is held
	`CPS_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !m_tvalid)

	// a stalled result holds
	`CPS_ASSERT(a_result_holds, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// DC drives stay off, relay and LED agree
	`CPS_ASSERT(a_drives_consistent, clk, arst_n,
		m_tvalid |-> m_tdata[5] && m_tdata[6] && (m_tdata[4] == m_tdata[7]))

	// fault reset pulses only on reaching closed
	`CPS_ASSERT(a_pulse_when_closed, clk, arst_n,
		m_tvalid && m_tdata[11] |-> m_tdata[2:0] == cps_pkg::ST_CLOSED)

	// a non-off stage without the close request only follows a timeout fault
	`CPS_ASSERT(a_stage_needs_request, clk, arst_n,
		m_tvalid && m_tdata[2:0] != cps_pkg::ST_OFF && !m_tdata[10] |-> m_tdata[8] || m_tdata[9])

endmodule

bind contactor_precharge_sequencer_unit cps_checker u_cps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
